[design/fft_padded_size_rounder_assert.svh]
// Assertion macros for the padded size rounder checker.
`ifndef FFT_PADDED_SIZE_ROUNDER_ASSERT_SVH
`define FFT_PADDED_SIZE_ROUNDER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FPSR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/fpsr_pkg.sv]
package fpsr_pkg;

	localparam int DIM_BITS_DEF = 16;

	typedef enum logic [2:0] {
		MODE_NONE   = 3'd0,
		MODE_MULT2  = 3'd1,
		MODE_MULT4  = 3'd2,
		MODE_MULT8  = 3'd3,
		MODE_POW2   = 3'd4,
		MODE_SMOOTH = 3'd5
	} mode_t;

	// Inverse of an odd number modulo 2^64, by Newton steps.
	function automatic logic [63:0] odd_inverse(input logic [63:0] a);
		logic [63:0] x;
		x = a;
		for (int i = 0; i < 5; i++) begin
			x = x * (64'd2 - a * x);
		end
		return x;
	endfunction

endpackage

[design/fpsr_cfg_if.sv]
interface fpsr_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] padding_mode;

	modport source (output valid, padding_mode, input ready);
	modport sink (input valid, padding_mode, output ready);
endinterface

[design/fpsr_req_if.sv]
interface fpsr_req_if #(
	parameter int DIM_BITS = fpsr_pkg::DIM_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] dimension;
	logic                is_periodic;

	modport source (output valid, dimension, is_periodic, input ready);
	modport sink (input valid, dimension, is_periodic, output ready);
endinterface

[design/fpsr_rsp_if.sv]
interface fpsr_rsp_if #(
	parameter int SIZE_BITS = fpsr_pkg::DIM_BITS_DEF + 2
);
	logic                 valid;
	logic                 ready;
	logic [SIZE_BITS-1:0] padded_size;
	logic                 error;

	modport source (output valid, padded_size, error, input ready);
	modport sink (input valid, padded_size, error, output ready);
endinterface

[design/fft_padded_size_rounder.sv]
// Padded FFT length for one grid axis. A periodic axis returns its dimension, a dimension
// of one returns 1; otherwise the length 2*dimension-1 is kept or rounded up to a multiple
// of 2, 4 or 8, to a power of two, or to the smallest 5-smooth number at or above
// 2*dimension, as padding_mode selects; mode 6/7 or a zero dimension sets error with size 0.
// One word is in flight at a time: request.ready is low from the accepted word until its
// result is loaded, and then follows result.ready while that result waits.
// Plain, periodic, multiple and error cases go from idle straight to done; power of two
// doubles a candidate from one in ST_POW until it reaches the length. The 5-smooth search
// runs on one shared exact-division multiplier: each candidate is halved per factor of 2,
// tested for 3 in ST_DIV3 and for 5 in ST_DIV5 by modular inverse, and rejected for the
// next one up when neither divides, until a 5-smooth number is reached.
module fft_padded_size_rounder #(
	parameter int DIM_BITS = fpsr_pkg::DIM_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	fpsr_cfg_if.sink     cfg,
	fpsr_req_if.sink     request,
	fpsr_rsp_if.source   result
);

	localparam int W = DIM_BITS + 2;
	localparam logic [63:0] FULL = (64'd1 << W) - 64'd1;
	localparam logic [W-1:0] INV3 = W'(fpsr_pkg::odd_inverse(64'd3));
	localparam logic [W-1:0] INV5 = W'(fpsr_pkg::odd_inverse(64'd5));
	localparam logic [W-1:0] LIM3 = W'(FULL / 64'd3);
	localparam logic [W-1:0] LIM5 = W'(FULL / 64'd5);
	localparam logic [W-1:0] ONE = W'(1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_POW    = 6'b000010,
		ST_SMOOTH = 6'b000100,
		ST_DIV3   = 6'b001000,
		ST_DIV5   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t         st_q;
	logic [2:0]     mode_q;
	logic [W-1:0]   cand_q;
	logic [W-1:0]   work_q;
	logic [W-1:0]   prod_q;
	logic           err_q;
	logic [W-1:0]   size_q;
	logic           error_q;
	logic           valid_q;

	logic [W-1:0]   dim_w;
	logic [W-1:0]   len;
	logic [W-1:0]   mul_b;
	logic [W-1:0]   mul_lo;
	logic [W-1:0]   cand_inc;
	logic           accept;

	assign cfg.ready     = 1'b1;
	assign request.ready = (st_q == ST_IDLE) && (!valid_q || result.ready);
	assign accept        = request.valid && request.ready;

	assign result.valid       = valid_q;
	assign result.padded_size = size_q;
	assign result.error       = error_q;

	assign dim_w    = W'(request.dimension);
	assign len      = (dim_w << 1) - ONE;
	assign mul_b    = (st_q == ST_DIV3) ? INV5 : INV3;
	assign mul_lo   = work_q * mul_b;
	assign cand_inc = cand_q + ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 3'd0;
		end else if (cfg.valid) begin
			mode_q <= cfg.padding_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (st_q == ST_DONE) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_DONE;
						if (request.dimension != '0 && !request.is_periodic &&
								dim_w != ONE) begin
							if (mode_q == fpsr_pkg::MODE_POW2) begin
								st_q <= ST_POW;
							end else if (mode_q == fpsr_pkg::MODE_SMOOTH) begin
								st_q <= ST_SMOOTH;
							end
						end
					end
				end
				ST_POW: begin
					if (cand_q >= work_q) begin
						st_q <= ST_DONE;
					end
				end
				ST_SMOOTH: begin
					if (work_q == ONE) begin
						st_q <= ST_DONE;
					end else if (work_q[0]) begin
						st_q <= ST_DIV3;
					end
				end
				ST_DIV3: begin
					st_q <= (prod_q <= LIM3) ? ST_SMOOTH : ST_DIV5;
				end
				ST_DIV5: begin
					st_q <= ST_SMOOTH;
				end
				ST_DONE: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					err_q <= 1'b0;
					if (request.dimension == '0) begin
						cand_q <= '0;
						err_q  <= 1'b1;
					end else if (request.is_periodic) begin
						cand_q <= dim_w;
					end else if (dim_w == ONE) begin
						cand_q <= ONE;
					end else begin
						case (mode_q)
							fpsr_pkg::MODE_NONE:   cand_q <= len;
							fpsr_pkg::MODE_MULT2:  cand_q <= (len + W'(1)) & ~W'(1);
							fpsr_pkg::MODE_MULT4:  cand_q <= (len + W'(3)) & ~W'(3);
							fpsr_pkg::MODE_MULT8:  cand_q <= (len + W'(7)) & ~W'(7);
							fpsr_pkg::MODE_POW2: begin
								cand_q <= ONE;
								work_q <= len;
							end
							fpsr_pkg::MODE_SMOOTH: begin
								cand_q <= len + ONE;
								work_q <= len + ONE;
							end
							default: begin
								cand_q <= '0;
								err_q  <= 1'b1;
							end
						endcase
					end
				end
			end
			ST_POW: begin
				if (cand_q < work_q) begin
					cand_q <= cand_q << 1;
				end
			end
			ST_SMOOTH: begin
				if (work_q != ONE) begin
					if (!work_q[0]) begin
						work_q <= work_q >> 1;
					end else begin
						prod_q <= mul_lo;
					end
				end
			end
			ST_DIV3: begin
				if (prod_q <= LIM3) begin
					work_q <= prod_q;
				end else begin
					prod_q <= mul_lo;
				end
			end
			ST_DIV5: begin
				if (prod_q <= LIM5) begin
					work_q <= prod_q;
				end else begin
					cand_q <= cand_inc;
					work_q <= cand_inc;
				end
			end
			ST_DONE: begin
				size_q  <= cand_q;
				error_q <= err_q;
			end
			default: begin
			end
		endcase
	end

endmodule

[design/fpsr_checker.sv]
module fpsr_checker #(
	parameter int DIM_BITS = fpsr_pkg::DIM_BITS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [DIM_BITS+1:0] padded_size,
	input logic                error
);

`include "fft_padded_size_rounder_assert.svh"

	`FPSR_ASSERT_IMP(a_err_size, rsp_valid, error == (padded_size == '0), "error and zero size disagree")
	`FPSR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result word dropped")
	`FPSR_ASSERT_IMP(a_no_take, rsp_valid && !rsp_ready, !req_ready, "ready while result stalled")
	`FPSR_ASSERT_NXT(a_one_word, req_valid && req_ready, !req_ready, "second word taken while busy")

endmodule

bind fft_padded_size_rounder fpsr_checker #(.DIM_BITS(DIM_BITS)) u_fpsr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.rsp_valid   (result.valid),
	.rsp_ready   (result.ready),
	.padded_size (result.padded_size),
	.error       (result.error)
);

[bench/fft_padded_size_rounder_tb.sv]
`timescale 1ns / 100ps

module fft_padded_size_rounder_tb;

	localparam int DIM_BITS = fpsr_pkg::DIM_BITS_DEF;
	localparam int SIZE_BITS = DIM_BITS + 2;
	localparam logic [2:0] MODE_BAD_LO = 3'd6;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;
	localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int RANDOM_PHASES = 14;
	localparam int WORDS_PER_PHASE = 75;

	typedef struct packed {
		logic [SIZE_BITS-1:0] padded_size;
		logic                 error;
	} padded_result_t;

	class padded_size_scoreboard;
		logic [2:0] padding_mode;
		padded_result_t expected_sizes[$];
		int mismatches;

		function new();
			padding_mode = fpsr_pkg::MODE_NONE;
			mismatches = 0;
		endfunction

		function bit only_small_primes(int unsigned x);
			if (x == 0)
				return 1'b0;
			while (x % 2 == 0) x = x / 2;
			while (x % 3 == 0) x = x / 3;
			while (x % 5 == 0) x = x / 5;
			return x == 1;
		endfunction

		function padded_result_t round_padded_size(logic [DIM_BITS-1:0] dim, logic per);
			padded_result_t res;
			int unsigned len;
			int unsigned size;
			res.error = 1'b0;
			size = 0;
			if (dim == 0) begin
				res.error = 1'b1;
			end else if (per) begin
				size = 32'(dim);
			end else if (dim == 1) begin
				size = 1;
			end else begin
				len = 2 * int'(dim) - 1;
				case (padding_mode)
					fpsr_pkg::MODE_NONE:  size = len;
					fpsr_pkg::MODE_MULT2: size = (len + 1) & ~32'd1;
					fpsr_pkg::MODE_MULT4: size = (len + 3) & ~32'd3;
					fpsr_pkg::MODE_MULT8: size = (len + 7) & ~32'd7;
					fpsr_pkg::MODE_POW2: begin
						size = 1;
						while (size < len) size = size << 1;
					end
					fpsr_pkg::MODE_SMOOTH: begin
						size = len + 1;
						while (!only_small_primes(size)) size++;
					end
					default: res.error = 1'b1;
				endcase
			end
			res.padded_size = size[SIZE_BITS-1:0];
			return res;
		endfunction

		function void note_request(logic [DIM_BITS-1:0] dim, logic per);
			expected_sizes = {expected_sizes, round_padded_size(dim, per)};
		endfunction

		function int pending();
			return expected_sizes.size();
		endfunction

		function void check_result(logic [SIZE_BITS-1:0] size, logic err);
			padded_result_t exp;
			if (expected_sizes.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual size %0d error %0b",
					$time, size, err);
				mismatches++;
				return;
			end
			exp = expected_sizes.pop_front();
			if (size !== exp.padded_size) begin
				$display("%0t: padded_size mismatch, expected %0d, actual %0d",
					$time, exp.padded_size, size);
				mismatches++;
			end
			if (err !== exp.error) begin
				$display("%0t: error mismatch, expected %0b, actual %0b",
					$time, exp.error, err);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fpsr_cfg_if cfg_bus();
	fpsr_req_if #(.DIM_BITS(DIM_BITS)) req_bus();
	fpsr_rsp_if #(.SIZE_BITS(SIZE_BITS)) rsp_bus();

	fft_padded_size_rounder #(
		.DIM_BITS(DIM_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.request(req_bus),
		.result (rsp_bus)
	);

	padded_size_scoreboard sb = new();
	int burst_left = 0;
	bit steady_sender = 1'b0;
	int rx_cycle = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_word(input logic [DIM_BITS-1:0] dim, input logic per);
		int gap;
		if (burst_left == 0) begin
			gap = steady_sender ? 0 : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 12);
			if (gap != 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_bus.valid <= 1'b1;
		req_bus.dimension <= dim;
		req_bus.is_periodic <= per;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		sb.note_request(dim, per);
	endtask

	task automatic write_mode(input logic [2:0] mode);
		req_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.padding_mode <= mode;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		sb.padding_mode = mode;
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic [DIM_BITS-1:0] pick_dimension();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return DIM_BITS'($urandom_range(0, int'(DIM_MAX)));
		if (r < 14) begin
			case ($urandom_range(0, 4))
				0: return '0;
				1: return DIM_BITS'(1);
				2: return DIM_MAX;
				3: return DIM_MAX - DIM_BITS'(1);
				default: return DIM_BITS'(2);
			endcase
		end
		return DIM_BITS'($urandom_range(0, 1023));
	endfunction

	// hold ready high in some windows, stall at random elsewhere
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready)
				sb.check_result(rsp_bus.padded_size, rsp_bus.error);
			rx_cycle++;
			if (((rx_cycle >> 8) % 8) == 0)
				rsp_bus.ready <= 1'b1;
			else
				rsp_bus.ready <= ($urandom_range(0, 99) < 60);
		end
	end

	initial begin : watchdog
		int idle_count;
		idle_count = 0;
		while (idle_count < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				idle_count = 0;
			else
				idle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [2:0] mode_order[8];
		logic [2:0] mode;
		mode_order = '{MODE_BAD_HI, fpsr_pkg::MODE_NONE, fpsr_pkg::MODE_SMOOTH,
			fpsr_pkg::MODE_MULT2, MODE_BAD_LO, fpsr_pkg::MODE_POW2, fpsr_pkg::MODE_MULT4,
			fpsr_pkg::MODE_MULT8};
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.padding_mode = '0;
		req_bus.valid = 1'b0;
		req_bus.dimension = '0;
		req_bus.is_periodic = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(fpsr_pkg::MODE_NONE);
		send_word('0, 1'b0);
		send_word('0, 1'b1);
		send_word(DIM_BITS'(1), 1'b0);
		send_word(DIM_MAX, 1'b1);
		send_word(DIM_MAX, 1'b0);
		send_word(DIM_BITS'(2), 1'b0);
		write_mode(fpsr_pkg::MODE_MULT2);
		send_word(DIM_BITS'($urandom_range(2, 300)), 1'b0);
		write_mode(fpsr_pkg::MODE_MULT4);
		send_word(DIM_BITS'($urandom_range(2, 300)), 1'b0);
		write_mode(fpsr_pkg::MODE_MULT8);
		send_word(DIM_BITS'($urandom_range(2, 300)), 1'b0);
		write_mode(fpsr_pkg::MODE_POW2);
		send_word(DIM_BITS'($urandom_range(2, 300)), 1'b0);
		send_word(DIM_MAX, 1'b0);
		write_mode(fpsr_pkg::MODE_SMOOTH);
		send_word(DIM_BITS'($urandom_range(2, 300)), 1'b0);
		send_word(DIM_MAX, 1'b0);
		write_mode(MODE_BAD_LO);
		send_word(DIM_BITS'(1), 1'b0);
		send_word(DIM_BITS'(5), 1'b1);
		send_word(DIM_BITS'(7), 1'b0);
		write_mode(MODE_BAD_HI);
		send_word(DIM_BITS'($urandom_range(2, 300)), 1'b0);
		send_word('0, 1'b1);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			mode = (ph < 8) ? mode_order[ph] : 3'($urandom_range(0, 7));
			steady_sender = (ph % 4 == 0);
			write_mode(mode);
			for (int i = 0; i < WORDS_PER_PHASE; i++)
				send_word(pick_dimension(), $urandom_range(0, 3) == 0);
		end

		req_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
